@@ src/led_display_update_framer_core_defines.svh @@
// Assertion macros shared by the framer RTL.
`ifndef LED_DISPLAY_UPDATE_FRAMER_CORE_DEFINES_SVH
`define LED_DISPLAY_UPDATE_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LEDFRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LEDFRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/led_frm_pkg.sv @@
// ----------------------------------------------------------------------------
// led_frm_pkg
// Shared constants, types and the segment table of the update framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package led_frm_pkg;

  localparam int GRID_COUNT = 7;
  localparam int CMD_COUNT  = 4;
  localparam int LAST_STEP  = CMD_COUNT + GRID_COUNT - 1;
  localparam int STEP_W     = $clog2(LAST_STEP + 1);
  localparam int GRID_IDX_W = $clog2(GRID_COUNT);

  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int VALUE_W    = 16;
  localparam int DIGIT_W    = 4;
  localparam int SAT_W      = 14;
  localparam int BRIGHT_W   = 3;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_INDEX_W = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_WRITE_CMD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_CMD       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ON_BASE        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_BASE       = 3'd5;

  // sequencer steps: the commands and address before the grid words, then the first and last grid steps
  localparam logic [STEP_W-1:0] STEP_DATA_CMD = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_MODE_CMD = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_CTRL_CMD = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_ADDRESS  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_FIRST_GRID = STEP_W'(CMD_COUNT);
  localparam logic [STEP_W-1:0] STEP_LAST     = STEP_W'(LAST_STEP);

  localparam logic [BYTE_W-1:0]  ADDRESS_BYTE = 8'hC0;
  localparam logic [WORD_W-1:0]  POINT_MASK   = 16'h0004;
  localparam logic [WORD_W-1:0]  LAMP_MASK    = 16'h0800;
  localparam logic [COUNT_W-1:0] BYTE_BITS    = 5'd8;
  localparam logic [COUNT_W-1:0] WORD_BITS    = 5'd16;
  localparam logic [SAT_W-1:0]   VALUE_MAX    = 14'd9999;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;

  // reciprocal constants, exact for values up to 9999
  localparam logic [14:0] RECIP_1000 = 15'd16778;
  localparam logic [13:0] RECIP_100  = 14'd10486;
  localparam logic [12:0] RECIP_10   = 13'd6554;

  typedef logic [GRID_COUNT-1:0][WORD_W-1:0] grid_words_t;

  typedef struct packed {
    grid_words_t words;
  } frame_t;

  typedef struct packed {
    logic                  display_enable;
    logic [BRIGHT_W-1:0]   brightness;
    logic [BYTE_W-1:0]     data_write_command;
    logic [BYTE_W-1:0]     mode_command;
    logic [BYTE_W-1:0]     display_on_base;
    logic [BYTE_W-1:0]     display_off_base;
  } cfg_t;

  function automatic logic [WORD_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [WORD_W-1:0] w;
    case (d)
      4'd0:    w = 16'h0333;
      4'd1:    w = 16'h0210;
      4'd2:    w = 16'h0139;
      4'd3:    w = 16'h0239;
      4'd4:    w = 16'h021A;
      4'd5:    w = 16'h022B;
      4'd6:    w = 16'h032B;
      4'd7:    w = 16'h0211;
      4'd8:    w = 16'h033B;
      default: w = 16'h023B;
    endcase
    return w;
  endfunction

  function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] d);
    return (d > DIGIT_MAX) ? DIGIT_MAX : d;
  endfunction

endpackage

`default_nettype wire

@@ src/led_frm_if.sv @@
// ----------------------------------------------------------------------------
// led_frm_in_if / led_frm_out_if
// Valid/ready channels for display updates and serial transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface led_frm_in_if;
  import led_frm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   shown_value;
  logic                 decimal_point;
  logic                 red_lamp;
  logic                 green_lamp;
  logic [DIGIT_W-1:0]   grid0_digit;
  logic [DIGIT_W-1:0]   grid5_digit;
  logic [DIGIT_W-1:0]   grid6_digit;

  modport source (
    output valid, shown_value, decimal_point, red_lamp, green_lamp,
           grid0_digit, grid5_digit, grid6_digit,
    input  ready
  );
  modport sink (
    input  valid, shown_value, decimal_point, red_lamp, green_lamp,
           grid0_digit, grid5_digit, grid6_digit,
    output ready
  );
endinterface

interface led_frm_out_if;
  import led_frm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    serial_word;
  logic [COUNT_W-1:0]   bit_count;
  logic                 strobe_fall_before;
  logic                 strobe_rise_after;
  logic                 last_of_run;

  modport source (
    output valid, serial_word, bit_count, strobe_fall_before, strobe_rise_after,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, serial_word, bit_count, strobe_fall_before, strobe_rise_after,
           last_of_run,
    output ready
  );
endinterface

`default_nettype wire

@@ src/led_frm_front.sv @@
// ----------------------------------------------------------------------------
// led_frm_front
// Accepts updates, splits the value into decimal digits and builds grid words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_frm_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  led_frm_in_if.sink                  upd,
  input  wire logic                   queue_full,
  output logic                        push,
  output led_frm_pkg::frame_t         push_frame
);
  import led_frm_pkg::*;

  logic                 a_valid;
  logic [SAT_W-1:0]     a_value;
  logic [3:0]           a_q1000;
  logic [6:0]           a_q100;
  logic [9:0]           a_q10;
  logic                 a_point;
  logic                 a_red;
  logic                 a_green;
  logic [DIGIT_W-1:0]   a_g0;
  logic [DIGIT_W-1:0]   a_g5;
  logic [DIGIT_W-1:0]   a_g6;

  logic [SAT_W-1:0]     sat_value;
  logic [28:0]          prod1000;
  logic [27:0]          prod100;
  logic [26:0]          prod10;
  logic                 accept;

  logic [6:0]           hund_full;
  logic [9:0]           tens_full;
  logic [SAT_W-1:0]     ones_full;
  logic [DIGIT_W-1:0]   digit [7];
  logic [WORD_W-1:0]    word7 [7];

  assign upd.ready = !a_valid || !queue_full;
  assign accept    = upd.valid && upd.ready;
  assign push      = a_valid && !queue_full;

  assign sat_value = (upd.shown_value > VALUE_W'(VALUE_MAX)) ? VALUE_MAX
                                                           : upd.shown_value[SAT_W-1:0];
  assign prod1000  = 29'(sat_value) * 29'(RECIP_1000);
  assign prod100   = 28'(sat_value) * 28'(RECIP_100);
  assign prod10    = 27'(sat_value) * 27'(RECIP_10);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_value <= sat_value;
      a_q1000 <= prod1000[27:24];
      a_q100  <= prod100[26:20];
      a_q10   <= prod10[25:16];
      a_point <= upd.decimal_point;
      a_red   <= upd.red_lamp;
      a_green <= upd.green_lamp;
      a_g0    <= sat_digit(upd.grid0_digit);
      a_g5    <= sat_digit(upd.grid5_digit);
      a_g6    <= sat_digit(upd.grid6_digit);
    end
  end

  // remainder of each quotient against ten times the next coarser one
  assign hund_full = a_q100 - ({3'b000, a_q1000} << 3) - ({3'b000, a_q1000} << 1);
  assign tens_full = a_q10 - ({3'b000, a_q100} << 3) - ({3'b000, a_q100} << 1);
  assign ones_full = a_value - ({4'b0000, a_q10} << 3) - ({4'b0000, a_q10} << 1);

  always_comb begin
    digit[0] = a_g0;
    digit[1] = tens_full[DIGIT_W-1:0];
    digit[2] = a_q1000;
    digit[3] = hund_full[DIGIT_W-1:0];
    digit[4] = ones_full[DIGIT_W-1:0];
    digit[5] = a_g5;
    digit[6] = a_g6;
    for (int g = 0; g < 7; g++) begin
      word7[g] = seg_pattern(digit[g]);
    end
    word7[0] = a_point ? (word7[0] | POINT_MASK) : (word7[0] & ~POINT_MASK);
    word7[1] = a_red   ? (word7[1] | LAMP_MASK)  : (word7[1] & ~LAMP_MASK);
    word7[4] = a_green ? (word7[4] | LAMP_MASK)  : (word7[4] & ~LAMP_MASK);
    for (int g = 0; g < GRID_COUNT; g++) begin
      push_frame.words[g] = word7[g];
    end
  end

endmodule

`default_nettype wire

@@ src/led_frm_queue.sv @@
// ----------------------------------------------------------------------------
// led_frm_queue
// Short frame queue between the front and the transfer sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_frm_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire led_frm_pkg::frame_t    push_frame,
  input  wire logic                   pop,
  output logic                        full,
  output logic                        head_valid,
  output led_frm_pkg::frame_t         head_frame
);
  import led_frm_pkg::*;

  frame_t                entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCOUNT_W-1:0]   count;

  assign full       = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_frame = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCOUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCOUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_frame;
    end
  end

endmodule

`default_nettype wire

@@ src/led_frm_back.sv @@
// ----------------------------------------------------------------------------
// led_frm_back
// Walks one queued frame through its command, address and grid transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_frm_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire led_frm_pkg::cfg_t      cfg,
  input  wire logic                   head_valid,
  input  wire led_frm_pkg::frame_t    head_frame,
  output logic                        pop,
  led_frm_out_if.source               xfer
);
  import led_frm_pkg::*;

  logic [STEP_W-1:0]     step;
  logic                  advance;
  logic [GRID_IDX_W-1:0] grid_idx;
  logic [BYTE_W-1:0]     ctrl_byte;
  logic [WORD_W-1:0]     word_next;
  logic [COUNT_W-1:0]    count_next;
  logic                  fall_next;
  logic                  rise_next;
  logic                  last_next;

  assign advance   = head_valid && (!xfer.valid || xfer.ready);
  assign pop       = advance && (step == STEP_LAST);
  assign grid_idx  = GRID_IDX_W'(step - STEP_FIRST_GRID);
  assign ctrl_byte = (cfg.display_enable ? cfg.display_on_base : cfg.display_off_base)
                   | BYTE_W'(cfg.brightness);

  always_comb begin
    word_next  = head_frame.words[grid_idx];
    count_next = WORD_BITS;
    fall_next  = 1'b0;
    rise_next  = (step == STEP_LAST);
    last_next  = (step == STEP_LAST);
    unique case (step)
      STEP_DATA_CMD: begin
        word_next  = WORD_W'(cfg.data_write_command);
        count_next = BYTE_BITS;
        fall_next  = 1'b1;
        rise_next  = 1'b1;
      end
      STEP_MODE_CMD: begin
        word_next  = WORD_W'(cfg.mode_command);
        count_next = BYTE_BITS;
        fall_next  = 1'b1;
        rise_next  = 1'b1;
      end
      STEP_CTRL_CMD: begin
        word_next  = WORD_W'(ctrl_byte);
        count_next = BYTE_BITS;
        fall_next  = 1'b1;
        rise_next  = 1'b1;
      end
      STEP_ADDRESS: begin
        word_next  = WORD_W'(ADDRESS_BYTE);
        count_next = BYTE_BITS;
        fall_next  = 1'b1;
        rise_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_DATA_CMD;
      xfer.valid <= 1'b0;
    end else begin
      if (advance) begin
        xfer.valid <= 1'b1;
        step       <= (step == STEP_LAST) ? STEP_DATA_CMD : step + STEP_W'(1);
      end else if (xfer.ready) begin
        xfer.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      xfer.serial_word        <= word_next;
      xfer.bit_count          <= count_next;
      xfer.strobe_fall_before <= fall_next;
      xfer.strobe_rise_after  <= rise_next;
      xfer.last_of_run        <= last_next;
    end
  end

endmodule

`default_nettype wire

@@ src/led_display_update_framer_core.sv @@
// ----------------------------------------------------------------------------
// led_display_update_framer_core
// Turns one display update into the command, address and grid transfers
// that refresh a seven-segment LED controller.
// ----------------------------------------------------------------------------
//  channel  | direction | moves
//  upd      | in        | one display update per transaction
//  xfer     | out       | one serial transfer per transaction, 4 + GRID_COUNT per update
//  cfg_*    | in        | register write, one per cycle with cfg_wr_en
//
//  Each update costs 4 + GRID_COUNT transfers (11 with seven grids); the transfer
//  sequencer emits one transfer per cycle while xfer is not stalled, from the head
//  of a two-deep frame queue. An accepted update is registered in the front stage,
//  pushed into the queue while it is not full; the sequencer registers its transfers
//  onto xfer. Reset (synchronous, rst high) empties the front stage and queue,
//  restarts the sequencer and loads register defaults. A stalled xfer holds the
//  sequencer; upd keeps accepting until the front stage and queue are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_display_update_framer_core_defines.svh"

module led_display_update_framer_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  led_frm_in_if.sink                                  upd,
  led_frm_out_if.source                               xfer,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [led_frm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [led_frm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import led_frm_pkg::*;

  cfg_t    cfg;
  logic    queue_full;
  logic    push;
  frame_t  push_frame;
  logic    pop;
  logic    head_valid;
  frame_t  head_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_enable     <= 1'b0;
      cfg.brightness         <= 3'd0;
      cfg.data_write_command <= 8'd64;
      cfg.mode_command       <= 8'd3;
      cfg.display_on_base    <= 8'd136;
      cfg.display_off_base   <= 8'd128;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DISPLAY_ENABLE: cfg.display_enable     <= cfg_data[0];
        REG_BRIGHTNESS:     cfg.brightness         <= cfg_data[BRIGHT_W-1:0];
        REG_DATA_WRITE_CMD: cfg.data_write_command <= cfg_data;
        REG_MODE_CMD:       cfg.mode_command       <= cfg_data;
        REG_ON_BASE:        cfg.display_on_base    <= cfg_data;
        REG_OFF_BASE:       cfg.display_off_base   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  led_frm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .queue_full (queue_full),
    .push       (push),
    .push_frame (push_frame)
  );

  led_frm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  led_frm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_frame (head_frame),
    .pop        (pop),
    .xfer       (xfer)
  );

  `LEDFRM_ASSERT_SAME(a_no_push_when_full, push, !queue_full, "frame pushed into full queue")
  `LEDFRM_ASSERT_SAME(a_pop_needs_head, pop, head_valid, "frame popped from empty queue")
  `LEDFRM_ASSERT_NEXT(a_pop_ends_run, pop, xfer.valid && xfer.last_of_run,
                      "pop without last transfer")
  `LEDFRM_ASSERT_SAME(a_last_is_word, xfer.valid && xfer.last_of_run,
                      xfer.strobe_rise_after && (xfer.bit_count == WORD_BITS),
                      "last transfer not a closing grid word")

endmodule

`default_nettype wire

@@ bench/tb_led_display_update_framer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_display_update_framer_core
// Feeds display updates through the upd channel, rebuilds the eleven
// transfers of each update from a local model of the framer and compares
// every xfer transaction against them, under several register settings
// and with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_led_display_update_framer_core;
  import led_frm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int PHASE_ITEMS = 41;
  localparam int MAX_GAP = 5;

  // segment patterns, digit 9 leftmost
  localparam logic [9:0][WORD_W-1:0] SEG_CODE = {
    16'h023B, 16'h033B, 16'h0211, 16'h032B, 16'h022B,
    16'h021A, 16'h0239, 16'h0139, 16'h0210, 16'h0333
  };

  typedef struct packed {
    logic [VALUE_W-1:0] shown_value;
    logic               decimal_point;
    logic               red_lamp;
    logic               green_lamp;
    logic [DIGIT_W-1:0] grid0_digit;
    logic [DIGIT_W-1:0] grid5_digit;
    logic [DIGIT_W-1:0] grid6_digit;
  } update_t;

  typedef struct packed {
    logic [WORD_W-1:0]  serial_word;
    logic [COUNT_W-1:0] bit_count;
    logic               strobe_fall;
    logic               strobe_rise;
    logic               run_last;
  } xfer_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  led_frm_in_if  upd_ch ();
  led_frm_out_if xfer_ch ();

  led_display_update_framer_core dut (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd_ch),
    .xfer      (xfer_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  cfg_t    regs_now;
  update_t update_backlog[$];
  xfer_t   pending_xfers[$];
  update_t cur_upd;
  int      updates_queued = 0;
  int      updates_taken = 0;
  int      xfers_checked = 0;
  int      fault_count = 0;
  int      settings_run = 0;
  bit      idle_en = 1'b1;
  int      upd_gap = 0;
  int      xfer_stall = 0;

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endfunction

  function automatic void queue_xfer(input logic [WORD_W-1:0] word,
                                     input logic [COUNT_W-1:0] bits,
                                     input logic fall, input logic rise,
                                     input logic last_one);
    xfer_t t;
    t.serial_word = word;
    t.bit_count   = bits;
    t.strobe_fall = fall;
    t.strobe_rise = rise;
    t.run_last    = last_one;
    pending_xfers.push_back(t);
  endfunction

  // Build the command, address and grid transfers of one update.
  function automatic void frame_update(input update_t u);
    logic [13:0]        shown;
    logic [DIGIT_W-1:0] digit [7];
    logic [BYTE_W-1:0]  ctrl;
    logic [WORD_W-1:0]  word;
    int                 g;
    shown    = (u.shown_value > 16'd9999) ? 14'd9999 : u.shown_value[13:0];
    digit[0] = (u.grid0_digit > 4'd9) ? 4'd9 : u.grid0_digit;
    digit[1] = 4'((shown / 10) % 10);
    digit[2] = 4'(shown / 1000);
    digit[3] = 4'((shown / 100) % 10);
    digit[4] = 4'(shown % 10);
    digit[5] = (u.grid5_digit > 4'd9) ? 4'd9 : u.grid5_digit;
    digit[6] = (u.grid6_digit > 4'd9) ? 4'd9 : u.grid6_digit;
    ctrl = regs_now.display_enable ? regs_now.display_on_base : regs_now.display_off_base;
    ctrl = ctrl | {5'd0, regs_now.brightness};
    queue_xfer({8'h00, regs_now.data_write_command}, BYTE_BITS, 1'b1, 1'b1, 1'b0);
    queue_xfer({8'h00, regs_now.mode_command}, BYTE_BITS, 1'b1, 1'b1, 1'b0);
    queue_xfer({8'h00, ctrl}, BYTE_BITS, 1'b1, 1'b1, 1'b0);
    queue_xfer({8'h00, ADDRESS_BYTE}, BYTE_BITS, 1'b1, 1'b0, 1'b0);
    for (g = 0; g < GRID_COUNT; g++) begin
      word = SEG_CODE[digit[g]];
      if (g == 0) begin
        word = u.decimal_point ? (word | POINT_MASK) : (word & ~POINT_MASK);
      end else if (g == 1) begin
        word = u.red_lamp ? (word | LAMP_MASK) : (word & ~LAMP_MASK);
      end else if (g == 4) begin
        word = u.green_lamp ? (word | LAMP_MASK) : (word & ~LAMP_MASK);
      end
      queue_xfer(word, WORD_BITS, 1'b0, g == GRID_COUNT - 1, g == GRID_COUNT - 1);
    end
  endfunction

  function automatic update_t make_update(input int value, input bit dp, input bit red,
                                          input bit green, input int d0, input int d5,
                                          input int d6);
    update_t u;
    u.shown_value   = VALUE_W'(value);
    u.decimal_point = dp;
    u.red_lamp      = red;
    u.green_lamp    = green;
    u.grid0_digit   = DIGIT_W'(d0);
    u.grid5_digit   = DIGIT_W'(d5);
    u.grid6_digit   = DIGIT_W'(d6);
    return u;
  endfunction

  // Mostly legal digits, now and then one that saturates.
  function automatic int draw_digit();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 9);
  endfunction

  function automatic update_t random_update();
    int pick;
    int value;
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      value = $urandom_range(0, 9999);
    end else if (pick < 17) begin
      value = $urandom_range(0, 65535);
    end else if (pick == 17) begin
      value = 9999;
    end else if (pick == 18) begin
      value = 10000;
    end else begin
      value = 65535;
    end
    return make_update(value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), draw_digit(), draw_digit(), draw_digit());
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.display_enable     = 1'($urandom_range(0, 1));
    c.brightness         = BRIGHT_W'($urandom_range(0, 7));
    c.data_write_command = BYTE_W'($urandom_range(0, 255));
    c.mode_command       = BYTE_W'($urandom_range(0, 255));
    c.display_on_base    = BYTE_W'($urandom_range(0, 255));
    c.display_off_base   = BYTE_W'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic add_update(input update_t u);
    update_backlog.push_back(u);
    updates_queued++;
  endtask

  task automatic drain();
    while (updates_taken != updates_queued || pending_xfers.size() != 0) @(posedge clk);
  endtask

  // Raise the write strobe for one register; the caller drops it after the last one.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DISPLAY_ENABLE: regs_now.display_enable     = val[0];
      REG_BRIGHTNESS:     regs_now.brightness         = val[BRIGHT_W-1:0];
      REG_DATA_WRITE_CMD: regs_now.data_write_command = val;
      REG_MODE_CMD:       regs_now.mode_command       = val;
      REG_ON_BASE:        regs_now.display_on_base    = val;
      REG_OFF_BASE:       regs_now.display_off_base   = val;
      default: ;
    endcase
  endtask

  task automatic run_setting(input cfg_t c, input bit idle, input int n);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_DISPLAY_ENABLE, {7'd0, c.display_enable});
    write_reg(REG_BRIGHTNESS, {5'd0, c.brightness});
    write_reg(REG_DATA_WRITE_CMD, c.data_write_command);
    write_reg(REG_MODE_CMD, c.mode_command);
    write_reg(REG_ON_BASE, c.display_on_base);
    write_reg(REG_OFF_BASE, c.display_off_base);
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    idle_en = idle;
    repeat (n) add_update(random_update());
    drain();
    settings_run++;
  endtask

  // Update driver: hold each transaction until accepted, then wait its gap.
  always @(posedge clk) begin
    if (rst) begin
      upd_ch.valid <= 1'b0;
      upd_gap = 0;
    end else begin
      if (upd_ch.valid && upd_ch.ready) begin
        frame_update(cur_upd);
        updates_taken++;
      end
      if (!upd_ch.valid || upd_ch.ready) begin
        if (upd_gap > 0) begin
          upd_gap--;
          upd_ch.valid <= 1'b0;
        end else if (update_backlog.size() != 0) begin
          cur_upd = update_backlog.pop_front();
          upd_ch.shown_value   <= cur_upd.shown_value;
          upd_ch.decimal_point <= cur_upd.decimal_point;
          upd_ch.red_lamp      <= cur_upd.red_lamp;
          upd_ch.green_lamp    <= cur_upd.green_lamp;
          upd_ch.grid0_digit   <= cur_upd.grid0_digit;
          upd_ch.grid5_digit   <= cur_upd.grid5_digit;
          upd_ch.grid6_digit   <= cur_upd.grid6_digit;
          upd_ch.valid         <= 1'b1;
          upd_gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          upd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Transfer monitor: check each transaction, then stall ready for a drawn count.
  always @(posedge clk) begin
    xfer_t got;
    xfer_t want;
    if (rst) begin
      xfer_ch.ready <= 1'b0;
      xfer_stall = 0;
    end else begin
      if (xfer_ch.valid && xfer_ch.ready) begin
        got.serial_word = xfer_ch.serial_word;
        got.bit_count   = xfer_ch.bit_count;
        got.strobe_fall = xfer_ch.strobe_fall_before;
        got.strobe_rise = xfer_ch.strobe_rise_after;
        got.run_last    = xfer_ch.last_of_run;
        if (pending_xfers.size() == 0) begin
          log_fault($sformatf("unexpected transfer word %h bits %0d fall %b rise %b last %b",
                              got.serial_word, got.bit_count, got.strobe_fall,
                              got.strobe_rise, got.run_last));
        end else begin
          want = pending_xfers.pop_front();
          xfers_checked++;
          if (got.serial_word !== want.serial_word || got.bit_count !== want.bit_count ||
              got.strobe_fall !== want.strobe_fall || got.strobe_rise !== want.strobe_rise ||
              got.run_last !== want.run_last) begin
            log_fault($sformatf({"transfer %0d: expected word %h bits %0d fall %b rise %b ",
                                 "last %b, got word %h bits %0d fall %b rise %b last %b"},
                                xfers_checked, want.serial_word, want.bit_count,
                                want.strobe_fall, want.strobe_rise, want.run_last,
                                got.serial_word, got.bit_count, got.strobe_fall,
                                got.strobe_rise, got.run_last));
          end
        end
        xfer_stall = idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (xfer_stall > 0) begin
        xfer_stall--;
        xfer_ch.ready <= 1'b0;
      end else begin
        xfer_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    int   k;
    upd_ch.valid         = 1'b0;
    upd_ch.shown_value   = '0;
    upd_ch.decimal_point = 1'b0;
    upd_ch.red_lamp      = 1'b0;
    upd_ch.green_lamp    = 1'b0;
    upd_ch.grid0_digit   = '0;
    upd_ch.grid5_digit   = '0;
    upd_ch.grid6_digit   = '0;
    xfer_ch.ready        = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    regs_now = {1'b0, 3'd0, 8'h40, 8'h03, 8'h88, 8'h80};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset register values; digit split edges, saturation, lamps and point.
    add_update(make_update(0, 0, 0, 0, 0, 0, 0));
    add_update(make_update(9999, 1, 1, 1, 9, 9, 9));
    add_update(make_update(10000, 0, 1, 0, 10, 11, 12));
    add_update(make_update(65535, 1, 0, 1, 15, 15, 15));
    add_update(make_update(1234, 1, 0, 0, 1, 2, 3));
    add_update(make_update(5678, 0, 0, 1, 4, 5, 6));
    add_update(make_update(9, 0, 1, 1, 7, 8, 0));
    add_update(make_update(10, 1, 1, 0, 13, 14, 10));
    add_update(make_update(99, 0, 0, 0, 8, 0, 7));
    add_update(make_update(100, 1, 0, 1, 2, 3, 4));
    add_update(make_update(999, 0, 1, 0, 5, 6, 1));
    add_update(make_update(1000, 1, 1, 1, 0, 9, 8));
    add_update(make_update(9990, 0, 0, 1, 3, 1, 2));
    add_update(make_update(8888, 1, 1, 1, 8, 8, 8));
    add_update(make_update(4321, 0, 1, 1, 6, 7, 5));
    add_update(make_update(7, 1, 0, 0, 14, 13, 11));
    drain();
    settings_run++;

    c = '1;
    run_setting(c, 1'b1, PHASE_ITEMS);
    c = '0;
    run_setting(c, 1'b0, PHASE_ITEMS);
    for (k = 0; k < 4; k++) begin
      c = random_cfg();
      if (k == 0) begin
        c.display_enable = 1'b0;
        c.brightness     = 3'd7;
      end
      run_setting(c, k != 2, PHASE_ITEMS);
    end

    repeat (30) @(posedge clk);
    if (pending_xfers.size() != 0) begin
      log_fault($sformatf("%0d expected transfers never arrived", pending_xfers.size()));
    end
    $display("Framed %0d display updates into %0d checked transfers over %0d register settings",
             updates_taken, xfers_checked, settings_run);
    $display("Mismatches: %0d", fault_count);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
